// ----- rtl/fwkrt_pkg.sv -----
// Shared constants and types of the first-wins key reverse table.
package fwkrt_pkg;

  localparam int ENTRIES_DEFAULT = 512;

  localparam int SYMBOL_W = 32;
  localparam int CODE_W   = 10;
  localparam int LIMIT_W  = 10;
  localparam int HELD_W   = 10;
  localparam int OUTCOME_W = 3;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd512;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  localparam logic [OUTCOME_W-1:0] OUT_INSERTED  = 3'd0;
  localparam logic [OUTCOME_W-1:0] OUT_DUPLICATE = 3'd1;
  localparam logic [OUTCOME_W-1:0] OUT_FULL      = 3'd2;
  localparam logic [OUTCOME_W-1:0] OUT_NULL      = 3'd3;
  localparam logic [OUTCOME_W-1:0] OUT_HIT       = 3'd4;
  localparam logic [OUTCOME_W-1:0] OUT_MISS      = 3'd5;

  typedef struct packed {
    logic [SYMBOL_W-1:0] symbol;
    logic [CODE_W-1:0]   code;
    logic                shift;
  } entry_t;

endpackage

// ----- rtl/first_wins_key_reverse_table.sv -----
// Top level of the first-wins key reverse table: entry memory, scan sequencer and result register.
//
// Maps 32-bit key symbols to a key code and shift flag, keeping the first mapping seen for
// each symbol. Entries live in one single-port-write, registered-read memory of ENTRIES words
// and are appended in insertion order; there is no flush other than reset, which only clears
// the fill count (no clearing pass, so the block is ready in the first cycle after reset).
// Every accepted transaction, insert or lookup, gives exactly one result. An insert or a
// lookup walks the held entries one memory read per cycle until the first match or the end
// of the fill, reading at most the fill count of entries (ENTRIES at worst); an insert of
// symbol zero skips the walk. One transaction is in the sequencer at a time; the result
// register lets the next transaction enter while the previous result still waits
// downstream. The table_limit register (reset 512, values above ENTRIES act as ENTRIES)
// caps appends; write it only while the block is idle, cfg_ready is always high.
module first_wins_key_reverse_table #(
  parameter int ENTRIES = fwkrt_pkg::ENTRIES_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fwkrt_pkg::LIMIT_W-1:0]    table_limit,
  // item channel
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic                             action,
  input  logic [fwkrt_pkg::SYMBOL_W-1:0]   key_symbol,
  input  logic [fwkrt_pkg::CODE_W-1:0]     key_code,
  input  logic                             shift_level,
  // result channel
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [fwkrt_pkg::OUTCOME_W-1:0]  outcome,
  output logic [fwkrt_pkg::CODE_W-1:0]     found_code,
  output logic                             found_shift,
  output logic [fwkrt_pkg::HELD_W-1:0]     entries_held
);

  localparam int AW    = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > fwkrt_pkg::LIMIT_W) ? CNT_W : fwkrt_pkg::LIMIT_W;

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]       state;
  logic [CNT_W-1:0] count;   // fill count, entries below it are valid
  logic [fwkrt_pkg::LIMIT_W-1:0] limit;

  // Transaction held for the duration of the walk
  logic                            act;
  logic [fwkrt_pkg::SYMBOL_W-1:0]  key;
  logic [fwkrt_pkg::CODE_W-1:0]    kcode;
  logic                            kshift;

  // Walk pointer and memory read pipeline
  logic [CNT_W-1:0]        ptr;
  logic                    rd_vld;
  fwkrt_pkg::entry_t       rd_q;
  fwkrt_pkg::entry_t       mem [ENTRIES];

  // Result waiting to enter the output register
  logic [fwkrt_pkg::OUTCOME_W-1:0] res_outcome;
  logic [fwkrt_pkg::CODE_W-1:0]    res_code;
  logic                            res_shift;

  logic item_take;
  logic issue;
  logic match;
  logic finish;
  logic full;
  logic ins_ok;
  logic out_free;

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != S_IDLE);
  assign item_take  = item_valid && (state == S_IDLE);

  // Issue one read per cycle while unread valid entries remain and no match is seen.
  assign match  = rd_vld && (rd_q.symbol == key);
  assign issue  = (state == S_SCAN) && (ptr < count) && !match;
  // The walk ends on a match, or once every issued read has returned without one.
  assign finish = (state == S_SCAN) && (match || (!rd_vld && (ptr >= count)));

  // Full when the count reached the register limit or the physical capacity.
  assign full   = (CMP_W'(count) >= CMP_W'(limit)) || (count >= CNT_W'(ENTRIES));
  assign ins_ok = (act == fwkrt_pkg::ACT_INSERT) && !match && !full;

  assign out_free = !result_valid || !result_stall;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      limit        <= fwkrt_pkg::LIMIT_RESET;
      rd_vld       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        limit <= table_limit;
      end
      rd_vld <= issue;
      // Load the output register from the sequencer, else drop a result once taken.
      if ((state == S_DONE) && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_take) begin
            // An insert of the null symbol needs no walk.
            if ((action == fwkrt_pkg::ACT_INSERT) && (key_symbol == '0)) begin
              state <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (finish) begin
            state <= S_DONE;
            if (ins_ok) begin
              count <= count + 1'b1;
            end
          end
        end
        S_DONE: begin
          // Hand over once the output register is empty or being drained.
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Transaction payload, walk pointer and result payload
  always_ff @(posedge clk) begin
    if (item_take) begin
      act         <= action;
      key         <= key_symbol;
      kcode       <= key_code;
      kshift      <= shift_level;
      ptr         <= '0;
      res_outcome <= fwkrt_pkg::OUT_NULL;
      res_code    <= '0;
      res_shift   <= 1'b0;
    end else if (issue) begin
      ptr <= ptr + 1'b1;
    end

    if (finish) begin
      res_code  <= '0;
      res_shift <= 1'b0;
      if (act == fwkrt_pkg::ACT_LOOKUP) begin
        if (match) begin
          res_outcome <= fwkrt_pkg::OUT_HIT;
          res_code    <= rd_q.code;
          res_shift   <= rd_q.shift;
        end else begin
          res_outcome <= fwkrt_pkg::OUT_MISS;
        end
      end else if (match) begin
        res_outcome <= fwkrt_pkg::OUT_DUPLICATE;
      end else if (full) begin
        res_outcome <= fwkrt_pkg::OUT_FULL;
      end else begin
        res_outcome <= fwkrt_pkg::OUT_INSERTED;
      end
    end

    if ((state == S_DONE) && out_free) begin
      outcome      <= res_outcome;
      found_code   <= res_code;
      found_shift  <= res_shift;
      // The count already includes this transaction's append.
      entries_held <= fwkrt_pkg::HELD_W'(count);
    end
  end

  // Entry memory: append at the fill count, registered read at the walk pointer.
  always_ff @(posedge clk) begin
    if (finish && ins_ok) begin
      mem[count[AW-1:0]] <= '{symbol: key, code: kcode, shift: kshift};
    end
    rd_q <= mem[ptr[AW-1:0]];
  end

endmodule

// ----- rtl/fwkrt_check.sv -----
// Port-level checker for the first-wins key reverse table, bound to the top level.
module fwkrt_check (
  input logic                             clk,
  input logic                             rst,
  input logic                             item_valid,
  input logic                             item_stall,
  input logic                             result_valid,
  input logic                             result_stall,
  input logic [fwkrt_pkg::OUTCOME_W-1:0]  outcome,
  input logic [fwkrt_pkg::CODE_W-1:0]     found_code,
  input logic                             found_shift,
  input logic [fwkrt_pkg::HELD_W-1:0]     entries_held
);

  // No result straight out of reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // A stalled result holds.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(outcome) && $stable(found_code) &&
      $stable(found_shift) && $stable(entries_held))
    else $error("stalled result changed");

  // Only a hit carries a code and shift flag.
  a_found_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (outcome != fwkrt_pkg::OUT_HIT) |->
      (found_code == '0) && (found_shift == 1'b0))
    else $error("non-hit result carries data");

  // One transaction at a time: the block is busy right after taking one.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("second transaction taken while busy");

endmodule

bind first_wins_key_reverse_table fwkrt_check u_fwkrt_check (.*);
